@@ hdl/qtrm_pkg.sv @@
package qtrm_pkg;

   localparam int QW  = 16;
   localparam int EW  = 32;
   localparam int AW  = 22;
   localparam int AFR = 12;
   localparam int DW  = 65;
   localparam int RW  = 65;
   localparam int QB  = 32;
   localparam int DSH = 25;

   typedef struct packed {
      logic signed [QW-1:0] q_w;
      logic signed [QW-1:0] q_x;
      logic signed [QW-1:0] q_y;
      logic signed [QW-1:0] q_z;
   } req_type;

   typedef struct packed {
      logic                 which_matrix;
      logic [1:0]           row_index;
      logic signed [EW-1:0] elem_0;
      logic signed [EW-1:0] elem_1;
      logic signed [EW-1:0] elem_2;
      logic signed [EW-1:0] elem_3;
      logic                 norm_zero;
      logic                 saturated;
      logic                 last_row;
   } rsp_type;

   typedef struct packed {
      logic                nz;
      logic [3:0]          qneg;
      logic [8:0][AW-1:0]  a;
   } side_type;

   function automatic logic b_neg(input logic [1:0] r, input logic [1:0] c);
      logic [3:0] m;
      case (r)
         2'd0: m = 4'b1110;
         2'd1: m = 4'b0100;
         2'd2: m = 4'b1000;
         2'd3: m = 4'b0010;
         default: m = 4'b0000;
      endcase
      return m[c];
   endfunction

   function automatic logic signed [EW-1:0] sx32(input logic signed [QW-1:0] v);
      return {{(EW-QW){v[QW-1]}}, v};
   endfunction

endpackage

@@ hdl/quaternion_to_rotation_matrix.sv @@
// Takes one quaternion (Q1.14) per input beat and returns seven result beats: the three
// rows of the rotation matrix A, then the four rows of the left-multiplication matrix B
// scaled by 0.5/|q|^4, all in saturated Q15.16. The single result port limits throughput,
// since each quaternion holds it for all of its result beats; a new quaternion is taken while
// the previous one still drains. A 32-stage restoring divider forms the B scale against |q|^4.
module quaternion_to_rotation_matrix (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  qtrm_pkg::req_type   req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output qtrm_pkg::rsp_type   rsp_payload
);
   import qtrm_pkg::*;

   typedef struct packed {
      side_type             side;
      logic [3:0][EW-1:0]   pos;
      logic [3:0][EW-1:0]   negv;
      logic [3:0]           psat;
      logic [3:0]           nsat;
   } item_type;

   localparam logic [2:0] ROWS_A   = 3'd3;
   localparam logic [2:0] LAST_ROW = 3'd6;

   logic adv;

   logic    v1_ff;
   req_type q1_ff;

   logic                      v2_ff;
   logic [3:0][EW-1:0]        sq2_ff, sq2_in;
   logic signed [EW-1:0]      px2_ff [6];
   logic signed [EW-1:0]      px2_in [6];
   logic [3:0][QW-1:0]        mag2_ff, mag2_in;
   logic [3:0]                neg2_ff, neg2_in;

   logic                      v3_ff;
   logic [EW:0]               s3_ff, s3_in;
   logic [3:0][QW-1:0]        mag3_ff;
   side_type                  side3_ff, side3_in;
   logic signed [EW+1:0]      av [9];
   logic signed [EW+1:0]      sqx [4];
   logic signed [EW+1:0]      pxx [6];

   logic                      v4_ff;
   logic [33:0]               hh4_ff, hh4_in;
   logic [32:0]               hl4_ff, hl4_in;
   logic [31:0]               ll4_ff, ll4_in;
   logic [3:0][QW-1:0]        mag4_ff;
   side_type                  side4_ff;

   logic                      v5_ff;
   logic [DW-1:0]             d5_ff, d5_in;
   logic [3:0][QW-1:0]        mag5_ff;
   side_type                  side5_ff;

   logic                      dv;
   logic [3:0][QB:0]          dquo;
   side_type                  dside;

   logic     finv_ff;
   item_type fin_ff, fin_in;
   logic     holdv_ff, holdv_in;
   item_type hold_ff;
   logic     busy_ff, busy_in;
   logic [2:0] cnt_ff, cnt_in;
   item_type cur_ff;
   logic     seq_load;

   assign adv       = ~finv_ff | ~holdv_ff;
   assign req_ready = adv;

   always_comb begin
      mag2_in[0] = q1_ff.q_w[QW-1] ? QW'(~q1_ff.q_w + 1'b1) : q1_ff.q_w;
      mag2_in[1] = q1_ff.q_x[QW-1] ? QW'(~q1_ff.q_x + 1'b1) : q1_ff.q_x;
      mag2_in[2] = q1_ff.q_y[QW-1] ? QW'(~q1_ff.q_y + 1'b1) : q1_ff.q_y;
      mag2_in[3] = q1_ff.q_z[QW-1] ? QW'(~q1_ff.q_z + 1'b1) : q1_ff.q_z;
      neg2_in    = {q1_ff.q_z[QW-1], q1_ff.q_y[QW-1], q1_ff.q_x[QW-1], q1_ff.q_w[QW-1]};
      sq2_in[0]  = sx32(q1_ff.q_w) * sx32(q1_ff.q_w);
      sq2_in[1]  = sx32(q1_ff.q_x) * sx32(q1_ff.q_x);
      sq2_in[2]  = sx32(q1_ff.q_y) * sx32(q1_ff.q_y);
      sq2_in[3]  = sx32(q1_ff.q_z) * sx32(q1_ff.q_z);
      px2_in[0]  = sx32(q1_ff.q_w) * sx32(q1_ff.q_x);
      px2_in[1]  = sx32(q1_ff.q_w) * sx32(q1_ff.q_y);
      px2_in[2]  = sx32(q1_ff.q_w) * sx32(q1_ff.q_z);
      px2_in[3]  = sx32(q1_ff.q_x) * sx32(q1_ff.q_y);
      px2_in[4]  = sx32(q1_ff.q_x) * sx32(q1_ff.q_z);
      px2_in[5]  = sx32(q1_ff.q_y) * sx32(q1_ff.q_z);
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         sqx[k] = {2'b00, sq2_ff[k]};
      end
      for (int k = 0; k < 6; k++) begin
         pxx[k] = {{2{px2_ff[k][EW-1]}}, px2_ff[k]};
      end
      s3_in = (EW+1)'(sq2_ff[0]) + (EW+1)'(sq2_ff[1]) + (EW+1)'(sq2_ff[2])
            + (EW+1)'(sq2_ff[3]);
      av[0] = sqx[0] + sqx[1] - sqx[2] - sqx[3];
      av[1] = (pxx[3] + pxx[2]) <<< 1;
      av[2] = (pxx[4] - pxx[1]) <<< 1;
      av[3] = (pxx[3] - pxx[2]) <<< 1;
      av[4] = sqx[0] - sqx[1] + sqx[2] - sqx[3];
      av[5] = (pxx[5] + pxx[0]) <<< 1;
      av[6] = (pxx[4] + pxx[1]) <<< 1;
      av[7] = (pxx[5] - pxx[0]) <<< 1;
      av[8] = sqx[0] - sqx[1] - sqx[2] + sqx[3];
      side3_in.nz   = (s3_in == '0);
      side3_in.qneg = neg2_ff;
      for (int k = 0; k < 9; k++) begin
         side3_in.a[k] = av[k][AW+AFR-1:AFR];
      end
   end

   always_comb begin
      hh4_in = 34'(s3_ff[EW:16]) * 34'(s3_ff[EW:16]);
      hl4_in = 33'(s3_ff[EW:16]) * 33'(s3_ff[15:0]);
      ll4_in = 32'(s3_ff[15:0]) * 32'(s3_ff[15:0]);
      d5_in  = DW'({hh4_ff, 32'b0}) + DW'({hl4_ff, 17'b0}) + DW'(ll4_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
      if (adv) begin
         q1_ff    <= req_payload;
         sq2_ff   <= sq2_in;
         px2_ff   <= px2_in;
         mag2_ff  <= mag2_in;
         neg2_ff  <= neg2_in;
         s3_ff    <= s3_in;
         mag3_ff  <= mag2_ff;
         side3_ff <= side3_in;
         hh4_ff   <= hh4_in;
         hl4_ff   <= hl4_in;
         ll4_ff   <= ll4_in;
         mag4_ff  <= mag3_ff;
         side4_ff <= side3_ff;
         d5_ff    <= d5_in;
         mag5_ff  <= mag4_ff;
         side5_ff <= side4_ff;
      end
   end

   qtrm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v5_ff),
      .in_d      (d5_ff),
      .in_mag    (mag5_ff),
      .in_side   (side5_ff),
      .out_valid (dv),
      .out_quo   (dquo),
      .out_side  (dside)
   );

   always_comb begin
      fin_in.side = dside;
      for (int k = 0; k < 4; k++) begin
         if (dside.nz) begin
            fin_in.pos[k]  = '0;
            fin_in.negv[k] = '0;
            fin_in.psat[k] = 1'b0;
            fin_in.nsat[k] = 1'b0;
         end else begin
            fin_in.psat[k] = dquo[k][QB] | dquo[k][QB-1];
            fin_in.pos[k]  = fin_in.psat[k] ? {1'b0, {(EW-1){1'b1}}}
                                            : {1'b0, dquo[k][QB-2:0]};
            fin_in.nsat[k] = dquo[k][QB] | (dquo[k][QB-1] & (|dquo[k][QB-2:0]));
            fin_in.negv[k] = fin_in.nsat[k] ? {1'b1, {(EW-1){1'b0}}}
                                            : EW'(~dquo[k][QB-1:0] + 1'b1);
         end
      end
   end

   assign seq_load = holdv_ff & (~busy_ff | ((cnt_ff == LAST_ROW) & rsp_ready));

   always_comb begin
      holdv_in = (adv & finv_ff) | (holdv_ff & ~seq_load);
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      if (busy_ff & rsp_ready) begin
         if (cnt_ff == LAST_ROW) begin
            busy_in = 1'b0;
            cnt_in  = '0;
         end else begin
            cnt_in = cnt_ff + 3'd1;
         end
      end
      if (seq_load) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         finv_ff  <= 1'b0;
         holdv_ff <= 1'b0;
         busy_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         if (adv) begin
            finv_ff <= dv;
         end
         holdv_ff <= holdv_in;
         busy_ff  <= busy_in;
         cnt_ff   <= cnt_in;
      end
      if (adv) begin
         fin_ff <= fin_in;
      end
      if (adv & finv_ff) begin
         hold_ff <= fin_ff;
      end
      if (seq_load) begin
         cur_ff <= hold_ff;
      end
   end

   always_comb begin
      logic [3:0][EW-1:0] ev;
      logic [1:0]         r;
      logic [1:0]         idx;
      logic               nb;
      logic               sat;
      ev  = '0;
      sat = 1'b0;
      r   = 2'(cnt_ff - ROWS_A);
      idx = '0;
      nb  = 1'b0;
      case (cnt_ff)
         3'd0: begin
            for (int c = 0; c < 3; c++) ev[c] = EW'(signed'(cur_ff.side.a[c]));
         end
         3'd1: begin
            for (int c = 0; c < 3; c++) ev[c] = EW'(signed'(cur_ff.side.a[3+c]));
         end
         3'd2: begin
            for (int c = 0; c < 3; c++) ev[c] = EW'(signed'(cur_ff.side.a[6+c]));
         end
         default: begin
            for (int c = 0; c < 4; c++) begin
               idx   = r ^ 2'(c);
               nb    = b_neg(r, 2'(c)) ^ cur_ff.side.qneg[idx];
               ev[c] = nb ? cur_ff.negv[idx] : cur_ff.pos[idx];
               sat   = sat | (nb ? cur_ff.nsat[idx] : cur_ff.psat[idx]);
            end
         end
      endcase
      rsp_payload.which_matrix = (cnt_ff >= ROWS_A);
      rsp_payload.row_index    = (cnt_ff >= ROWS_A) ? r : cnt_ff[1:0];
      rsp_payload.elem_0       = ev[0];
      rsp_payload.elem_1       = ev[1];
      rsp_payload.elem_2       = ev[2];
      rsp_payload.elem_3       = ev[3];
      rsp_payload.norm_zero    = cur_ff.side.nz;
      rsp_payload.saturated    = sat;
      rsp_payload.last_row     = (cnt_ff == LAST_ROW);
   end

   assign rsp_valid = busy_ff;

endmodule

@@ hdl/qtrm_div.sv @@
module qtrm_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic                           in_valid,
   input  logic [qtrm_pkg::DW-1:0]        in_d,
   input  logic [3:0][qtrm_pkg::QW-1:0]   in_mag,
   input  qtrm_pkg::side_type             in_side,
   output logic                           out_valid,
   output logic [3:0][qtrm_pkg::QB:0]     out_quo,
   output qtrm_pkg::side_type             out_side
);
   import qtrm_pkg::*;

   logic [QB-1:0] v_ff;
   logic [QB-1:0] v_src;
   logic [DW-1:0] d_ff [QB];
   logic [DW-1:0] d_src [QB];
   logic [RW-1:0] rem_ff [QB][4];
   logic [RW-1:0] rem_src [QB][4];
   logic [RW-1:0] rem_in [QB][4];
   logic [RW:0]   t_w [QB][4];
   logic [RW:0]   diff_w [QB][4];
   logic          ge_w [QB][4];
   logic [QB-1:0] quo_ff [QB][4];
   logic [QB-1:0] quo_src [QB][4];
   logic [QB-1:0] quo_in [QB][4];
   logic [3:0]    cap_ff [QB];
   logic [3:0]    cap_src [QB];
   side_type      side_ff [QB];
   side_type      side_src [QB];

   always_comb begin
      for (int s = 0; s < QB; s++) begin
         if (s == 0) begin
            v_src[s]    = in_valid;
            d_src[s]    = in_d;
            side_src[s] = in_side;
            for (int k = 0; k < 4; k++) begin
               rem_src[s][k] = {{(RW-QW-DSH){1'b0}}, in_mag[k], {DSH{1'b0}}};
               quo_src[s][k] = '0;
               cap_src[s][k] = ({{(RW-QW-DSH){1'b0}}, in_mag[k], {DSH{1'b0}}} >= in_d);
            end
         end else begin
            v_src[s]    = v_ff[s-1];
            d_src[s]    = d_ff[s-1];
            side_src[s] = side_ff[s-1];
            cap_src[s]  = cap_ff[s-1];
            for (int k = 0; k < 4; k++) begin
               rem_src[s][k] = rem_ff[s-1][k];
               quo_src[s][k] = quo_ff[s-1][k];
            end
         end
      end
   end

   always_comb begin
      for (int s = 0; s < QB; s++) begin
         for (int k = 0; k < 4; k++) begin
            t_w[s][k]    = {rem_src[s][k], 1'b0};
            diff_w[s][k] = t_w[s][k] - {1'b0, d_src[s]};
            ge_w[s][k]   = (t_w[s][k] >= {1'b0, d_src[s]});
            rem_in[s][k] = ge_w[s][k] ? diff_w[s][k][RW-1:0] : t_w[s][k][RW-1:0];
            quo_in[s][k] = {quo_src[s][k][QB-2:0], ge_w[s][k]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_src;
      end
      if (adv) begin
         for (int s = 0; s < QB; s++) begin
            d_ff[s]    <= d_src[s];
            side_ff[s] <= side_src[s];
            cap_ff[s]  <= cap_src[s];
            for (int k = 0; k < 4; k++) begin
               rem_ff[s][k] <= rem_in[s][k];
               quo_ff[s][k] <= quo_in[s][k];
            end
         end
      end
   end

   always_comb begin
      out_valid = v_ff[QB-1];
      out_side  = side_ff[QB-1];
      for (int k = 0; k < 4; k++) begin
         out_quo[k] = cap_ff[QB-1][k] ? {1'b1, {QB{1'b0}}} : {1'b0, quo_ff[QB-1][k]};
      end
   end

endmodule
